FILE: rtl/core/sgpj_pkg.sv
// sgpj_pkg: field widths, group phase codes and the stored taxi entry type
// for the sorted group pair join; no dependencies
`default_nettype none

package sgpj_pkg;

  localparam int unsigned TimeW = 31;
  localparam int unsigned LatW  = 31;
  localparam int unsigned LonW  = 32;
  localparam int unsigned IdW   = 16;
  localparam int unsigned LineW = 32;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'b001,
    PH_TAXI  = 3'b010,
    PH_TWEET = 3'b100
  } phase_e;

  typedef struct packed {
    logic [IdW-1:0]   ident;
    logic [LineW-1:0] line;
  } taxi_entry_t;

endpackage

`default_nettype wire

FILE: rtl/core/sorted_group_pair_join.sv
// sorted_group_pair_join: groups sorted taxi records and emits one pair per buffered
// taxi for each matching tweet; depends on sgpj_pkg
//
// Input channel (in_valid_i/in_ready_o) takes one record per transfer: a taxi or a
// tweet with time, position, id and line number. Output channel (out_valid_o/
// out_ready_i) gives one taxi/tweet pair per transfer.
// Taxis and non-matching tweets do not hold the input and produce nothing.
// A matching tweet holds the input while its group of buffered taxis is read out:
// the taxi buffer has one write port and a registered read port, read at one entry
// per cycle while the output register takes them, and each read entry goes through
// the read data register to the output register. Pairs leave one per cycle while
// the receiver takes them; last_pair_o marks the final pair of the tweet.
// A stalled receiver holds the output register and the read pipeline in place;
// the next record is taken as soon as all reads of the tweet have been handed to
// the output register, so a finished pair may still wait there.
// Reset clears the phase (no open group), key, count and overflow flag; the buffer
// memory is not cleared, only entries below the count are read.
// Taxis beyond MAX_GROUP in one group are dropped and flagged in group_overflowed_o.
`default_nettype none

module sorted_group_pair_join #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                is_tweet_i,
  input  wire logic        [sgpj_pkg::TimeW-1:0]   epoch_time_i,
  input  wire logic signed [sgpj_pkg::LatW-1:0]    latitude_i,
  input  wire logic signed [sgpj_pkg::LonW-1:0]    longitude_i,
  input  wire logic        [sgpj_pkg::IdW-1:0]     record_id_i,
  input  wire logic        [sgpj_pkg::LineW-1:0]   line_number_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic             [sgpj_pkg::LineW-1:0]   taxi_line_o,
  output logic             [sgpj_pkg::IdW-1:0]     taxi_ident_o,
  output logic             [sgpj_pkg::LineW-1:0]   tweet_line_o,
  output logic             [sgpj_pkg::IdW-1:0]     hashtag_ident_o,
  output logic                                     last_pair_o,
  output logic                                     group_overflowed_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUP + 1);
  localparam int unsigned IdxW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_GROUP);

  sgpj_pkg::phase_e phase_q, phase_d;
  logic        [sgpj_pkg::TimeW-1:0] grp_time_q, grp_time_d;
  logic signed [sgpj_pkg::LatW-1:0]  grp_lat_q, grp_lat_d;
  logic signed [sgpj_pkg::LonW-1:0]  grp_lon_q, grp_lon_d;
  logic [CntW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  logic            emit_q, emit_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic            rd_pend_q, rd_pend_d;
  logic            rd_last_q, rd_last_d;

  logic [sgpj_pkg::LineW-1:0] tw_line_q;
  logic [sgpj_pkg::IdW-1:0]   tw_hash_q;

  sgpj_pkg::taxi_entry_t mem_q [MAX_GROUP];
  sgpj_pkg::taxi_entry_t rd_data_q;

  logic            in_xfer, key_match, grp_open, mem_we, rd_en, load;
  logic [IdxW-1:0] wr_addr;
  logic [CntW-1:0] rd_idx_inc;

  logic                       out_valid_q;
  logic [sgpj_pkg::LineW-1:0] out_taxi_line_q, out_tweet_line_q;
  logic [sgpj_pkg::IdW-1:0]   out_taxi_id_q, out_hash_q;
  logic                       out_last_q, out_ovf_q;

  assign in_ready_o = !emit_q && !rd_pend_q;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign key_match  = (epoch_time_i == grp_time_q) && (latitude_i == grp_lat_q) &&
                      (longitude_i == grp_lon_q);
  assign grp_open   = (phase_q == sgpj_pkg::PH_TAXI) || (phase_q == sgpj_pkg::PH_TWEET);

  assign load       = rd_pend_q && (!out_valid_q || out_ready_i);
  assign rd_en      = emit_q && (!rd_pend_q || load);
  assign rd_idx_inc = rd_idx_q + CntW'(1);

  always_comb begin
    phase_d    = phase_q;
    grp_time_d = grp_time_q;
    grp_lat_d  = grp_lat_q;
    grp_lon_d  = grp_lon_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    emit_d     = emit_q;
    rd_idx_d   = rd_idx_q;
    rd_pend_d  = rd_pend_q;
    rd_last_d  = rd_last_q;
    mem_we     = 1'b0;
    wr_addr    = '0;
    if (in_xfer) begin
      if (!is_tweet_i) begin
        if ((phase_q == sgpj_pkg::PH_TAXI) && key_match) begin
          if (count_q < MaxCnt) begin
            mem_we  = 1'b1;
            wr_addr = count_q[IdxW-1:0];
            count_d = count_q + CntW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end else begin
          grp_time_d = epoch_time_i;
          grp_lat_d  = latitude_i;
          grp_lon_d  = longitude_i;
          mem_we     = 1'b1;
          wr_addr    = '0;
          count_d    = CntW'(1);
          ovf_d      = 1'b0;
          phase_d    = sgpj_pkg::PH_TAXI;
        end
      end else if (grp_open && key_match) begin
        phase_d  = sgpj_pkg::PH_TWEET;
        emit_d   = 1'b1;
        rd_idx_d = '0;
      end else begin
        phase_d = sgpj_pkg::PH_SKIP;
      end
    end
    if (load) begin
      rd_pend_d = 1'b0;
    end
    if (rd_en) begin
      rd_pend_d = 1'b1;
      rd_last_d = (rd_idx_inc == count_q);
      rd_idx_d  = rd_idx_inc;
      if (rd_idx_inc == count_q) begin
        emit_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= sgpj_pkg::PH_SKIP;
      grp_time_q  <= '0;
      grp_lat_q   <= '0;
      grp_lon_q   <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      emit_q      <= 1'b0;
      rd_idx_q    <= '0;
      rd_pend_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      grp_time_q <= grp_time_d;
      grp_lat_q  <= grp_lat_d;
      grp_lon_q  <= grp_lon_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      emit_q     <= emit_d;
      rd_idx_q   <= rd_idx_d;
      rd_pend_q  <= rd_pend_d;
      rd_last_q  <= rd_last_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // tweet fields for the pairs being read out
  always_ff @(posedge clk_i) begin
    if (in_xfer && is_tweet_i) begin
      tw_line_q <= line_number_i;
      tw_hash_q <= record_id_i;
    end
  end

  // taxi buffer, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= '{ident: record_id_i, line: line_number_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_idx_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_taxi_line_q  <= rd_data_q.line;
      out_taxi_id_q    <= rd_data_q.ident;
      out_tweet_line_q <= tw_line_q;
      out_hash_q       <= tw_hash_q;
      out_last_q       <= rd_last_q;
      out_ovf_q        <= ovf_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign taxi_line_o        = out_taxi_line_q;
  assign taxi_ident_o       = out_taxi_id_q;
  assign tweet_line_o       = out_tweet_line_q;
  assign hashtag_ident_o    = out_hash_q;
  assign last_pair_o        = out_last_q;
  assign group_overflowed_o = out_ovf_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt)
    else $error("taxi count beyond buffer depth");

  a_emit_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (phase_q == sgpj_pkg::PH_TWEET))
    else $error("readout outside tweet phase");

  a_emit_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q |-> (rd_idx_q < count_q))
    else $error("read index past group size");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_pend_q && rd_last_q) |-> !emit_q)
    else $error("reads continue after last entry");

  a_match_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_tweet_i && grp_open && key_match) |=> emit_q)
    else $error("matching tweet did not start readout");
`endif

endmodule

`default_nettype wire
